FILE: design/legr_pkg.sv
// shared types and constants for the legendre recursion coefficient core
// no dependencies; imported by the core, the root unit and the checker
package legr_pkg;

    // field widths
    localparam int DEG_W      = 6;
    localparam int COEF_W     = 32;
    localparam int STAT_W     = 2;

    // number format and limits
    localparam int MAX_DEGREE = 63;
    localparam int FRAC_BITS  = 18;
    localparam int DIAG_BITS  = 32;

    // root unit sizing: operand ranges and iteration count
    localparam int NUM_W      = 27;
    localparam int DEN_W      = 20;
    localparam int ROOT_BITS  = 40;
    localparam int BIT_W      = $clog2(ROOT_BITS);
    localparam int RW         = 2 * ROOT_BITS + DEN_W + 2;
    localparam int SHIFT_F    = 2 * (FRAC_BITS + 1);
    localparam int SHIFT_D    = 2 * (DIAG_BITS + 1);
    localparam int Y_SHIFT    = 2 * (ROOT_BITS - 1);

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_LOW_DEG = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic [DEG_W-1:0] degree_n;
        logic [DEG_W-1:0] order_m;
    } t_req;

    typedef struct packed {
        logic [COEF_W-1:0] xi_coeff;
        logic [COEF_W-1:0] eta_coeff;
        logic [COEF_W-1:0] zeta_coeff;
        logic [COEF_W-1:0] upsilon_coeff;
        logic [COEF_W-1:0] alpha_coeff;
        logic [COEF_W-1:0] beta_coeff;
        logic [COEF_W-1:0] diag_coeff;
        logic [STAT_W-1:0] status;
    } t_res;

    typedef struct packed {
        logic start;
        logic wide;
    } t_root_cmd;

endpackage

FILE: design/legr_root.sv
// bit-serial fixed-point root of a ratio: round(sqrt(num/den) * 2^f)
// one result bit per cycle; depends on legr_pkg
module legr_root (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  legr_pkg::t_root_cmd             i_cmd,
    input  logic [legr_pkg::NUM_W-1:0]      i_num,
    input  logic [legr_pkg::DEN_W-1:0]      i_den,
    output logic                            o_done,
    output logic [legr_pkg::ROOT_BITS-1:0]  o_root
);
    import legr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_zero;
    logic [BIT_W-1:0]     r_bit;
    logic [RW-1:0]        r_rem;
    logic [RW-1:0]        r_x;
    logic [RW-1:0]        r_y;
    logic [ROOT_BITS-1:0] r_t;

    logic [RW-1:0]        cand;
    logic                 take;
    logic [RW-1:0]        n_x;
    logic [RW-1:0]        n_rem;
    logic [ROOT_BITS:0]   t_inc;

    // trial: remainder against 2*t*den*2^b + den*2^2b
    always_comb begin
        cand  = r_x + r_y;
        take  = (cand <= r_rem);
        n_rem = take ? (r_rem - cand) : r_rem;
        n_x   = take ? ((r_x + (r_y << 1)) >> 1) : (r_x >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_bit  <= BIT_W'(ROOT_BITS - 1);
                r_rem  <= i_cmd.wide ? (RW'(i_num) << SHIFT_D) : (RW'(i_num) << SHIFT_F);
                r_x    <= '0;
                r_y    <= RW'(i_den) << Y_SHIFT;
                r_t    <= '0;
                r_zero <= (i_den == '0);
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_x   <= n_x;
                r_y   <= r_y >> 2;
                r_t   <= {r_t[ROOT_BITS-2:0], take};
                r_bit <= r_bit - 1'b1;
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // round half up by dropping the guard bit
    assign t_inc  = {1'b0, r_t} + 1'b1;
    assign o_root = r_zero ? '0 : t_inc[ROOT_BITS:1];
    assign o_done = r_done;

endmodule

FILE: design/legendre_recursion_coefficients_core.sv
// recursion coefficients for fully normalised associated legendre functions
// depends on legr_pkg and legr_root
//
// usage
// - request channel: degree_n and order_m on i_req, taken at a clock edge with
//   start high and busy low; busy stays high until the result is out
// - result channel: o_res is valid for exactly one cycle while o_done is high;
//   the receiver cannot stall, so o_res must be taken in that cycle
// - configuration: max_degree on i_cfg_data, written when i_cfg_valid and
//   o_cfg_ready are high; o_cfg_ready is always high, write only while idle
// - work: a flagged request goes from idle straight to the done state; a valid
//   request needs n+6 square roots in the shared bit-serial root unit, each
//   built from factor products and then 40 result bits, and n-1 products of
//   four partial 32x32 multiplies in the shared multiplier
// - throughput: one request at a time; the next may start the cycle the
//   result strobe is shown
// - reset: synchronous, active low; clears the sequencer, the strobe and
//   max_degree to zero; no clearing pass is needed
module legendre_recursion_coefficients_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  legr_pkg::t_req               i_req,
    output logic                         o_done,
    output legr_pkg::t_res               o_res,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [legr_pkg::DEG_W-1:0]   i_cfg_data
);
    import legr_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_FACT, S_ROOT, S_MUL, S_DONE} t_state;
    typedef enum logic [3:0] {
        J_XI, J_ETA, J_ZETA, J_UPS, J_ALPHA, J_BETA, J_S3, J_SK, J_Q
    } t_job;

    localparam int DS = 2 * DIAG_BITS - FRAC_BITS;

    t_state           r_state;
    t_job             r_job;
    logic [DEG_W-1:0] r_n;
    logic [DEG_W-1:0] r_m;
    logic [DEG_W-1:0] r_k;
    logic [DEG_W-1:0] r_maxdeg;
    logic [2:0]       r_fs;
    logic [2:0]       r_ms;
    logic [31:0]      r_num;
    logic [31:0]      r_den;
    logic [63:0]      r_p;
    logic [63:0]      r_b;
    logic [127:0]     r_acc;
    t_res             r_res;
    logic             r_done;

    logic [7:0]       fa [4];
    logic [7:0]       fd [3];
    logic             wide;
    logic [7:0]       n8, m8, n2, k2;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;
    logic [6:0]       mul_sh;
    logic [127:0]     rnd32, rnd46;
    logic [63:0]      p_next;
    logic [COEF_W-1:0] diag_val;
    logic [COEF_W-1:0] root_sat;
    logic [COEF_W-1:0] pair_val;
    t_root_cmd        root_cmd;
    logic             root_done;
    logic [ROOT_BITS-1:0] root_val;

    // factors of numerator and denominator for the current job
    always_comb begin
        n8 = {2'b00, r_n};
        m8 = {2'b00, r_m};
        n2 = {1'b0, r_n, 1'b0};
        k2 = {1'b0, r_k, 1'b0};
        fa[0] = 8'd1; fa[1] = 8'd1; fa[2] = 8'd1; fa[3] = 8'd1;
        fd[0] = 8'd1; fd[1] = 8'd1; fd[2] = 8'd1;
        wide  = 1'b0;
        unique case (r_job)
            J_XI: begin
                fa[0] = n2 - 8'd1; fa[1] = n2 + 8'd1;
                fd[0] = n8 + m8;   fd[1] = n8 - m8;
            end
            J_ETA: begin
                fa[0] = n2 + 8'd1; fa[1] = n8 + m8 - 8'd1; fa[2] = n8 - m8 - 8'd1;
                fd[0] = n8 + m8;   fd[1] = n8 - m8;        fd[2] = n2 - 8'd3;
            end
            J_ZETA: begin
                if (r_m == '0) begin
                    fa[0] = n8; fa[1] = n8 + 8'd1; fd[0] = 8'd2;
                end else begin
                    fa[0] = n8 - m8; fa[1] = n8 + m8 + 8'd1;
                end
            end
            J_UPS: begin
                if (r_m == '0) begin
                    fa[0] = n8; fa[1] = n8 - 8'd1; fa[2] = n8 + 8'd1; fa[3] = n8 + 8'd2;
                    fd[0] = 8'd2;
                end else begin
                    fa[0] = n8 - m8;        fa[1] = n8 + m8 + 8'd1;
                    fa[2] = n8 - m8 - 8'd1; fa[3] = n8 + m8 + 8'd2;
                end
            end
            J_ALPHA: begin
                fa[0] = n2 - 8'd1; fa[1] = n2 + 8'd1;
                fd[0] = n8;        fd[1] = n8;
            end
            J_BETA: begin
                fa[0] = n2 + 8'd1; fa[1] = n8 - 8'd1; fa[2] = n8 - 8'd1;
                fd[0] = n2 - 8'd3; fd[1] = n8;        fd[2] = n8;
            end
            J_S3: begin
                fa[0] = 8'd3; wide = 1'b1;
            end
            J_SK: begin
                fa[0] = k2 + 8'd1; fd[0] = k2; wide = 1'b1;
            end
            J_Q: begin
                fa[0] = n2 + 8'd1; wide = 1'b1;
            end
            default: begin
                wide = 1'b0;
            end
        endcase
    end

    // shared multiplier: factor products or partial products of the diagonal
    always_comb begin
        mul_a  = r_num;
        mul_b  = 32'(fa[r_fs[1:0]]);
        mul_sh = 7'd0;
        if (r_state == S_FACT && r_fs >= 3'd4) begin
            mul_a = r_den;
            mul_b = 32'(fd[r_fs[1:0] + 2'd1]);
        end else if (r_state == S_MUL) begin
            unique case (r_ms[1:0])
                2'd0: begin mul_a = r_p[31:0];  mul_b = r_b[31:0];  mul_sh = 7'd0;  end
                2'd1: begin mul_a = r_p[31:0];  mul_b = r_b[63:32]; mul_sh = 7'd32; end
                2'd2: begin mul_a = r_p[63:32]; mul_b = r_b[31:0];  mul_sh = 7'd32; end
                2'd3: begin mul_a = r_p[63:32]; mul_b = r_b[63:32]; mul_sh = 7'd64; end
            endcase
        end
        mul_p = mul_a * mul_b;
    end

    // rounding of the accumulated products
    always_comb begin
        rnd32    = r_acc + (128'd1 << (DIAG_BITS - 1));
        rnd46    = r_acc + (128'd1 << (DS - 1));
        p_next   = (|rnd32[127:2*DIAG_BITS+32]) ? '1 : rnd32[2*DIAG_BITS+31:DIAG_BITS];
        diag_val = (|rnd46[127:DS+COEF_W]) ? '1 : rnd46[DS+COEF_W-1:DS];
        root_sat = (|root_val[ROOT_BITS-1:COEF_W]) ? '1 : root_val[COEF_W-1:0];
        pair_val = (r_m == r_n) ? '0 : root_sat;
    end

    always_comb begin
        root_cmd.start = (r_state == S_FACT) && (r_fs == 3'd6);
        root_cmd.wide  = wide;
    end

    legr_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (root_cmd),
        .i_num   (r_num[NUM_W-1:0]),
        .i_den   (r_den[DEN_W-1:0]),
        .o_done  (root_done),
        .o_root  (root_val)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_maxdeg <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid) begin
                r_maxdeg <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_n <= i_req.degree_n;
                        r_m <= i_req.order_m;
                        if (i_req.degree_n > r_maxdeg ||
                            int'(i_req.degree_n) > MAX_DEGREE ||
                            i_req.order_m > i_req.degree_n) begin
                            r_res        <= '{status: ST_RANGE, default: '0};
                            r_state      <= S_DONE;
                        end else if (i_req.degree_n < DEG_W'(2)) begin
                            r_res        <= '{status: ST_LOW_DEG, default: '0};
                            r_state      <= S_DONE;
                        end else begin
                            r_res.status <= ST_OK;
                            r_job        <= J_XI;
                            r_fs         <= '0;
                            r_state      <= S_FACT;
                        end
                    end
                end
                // build numerator and denominator, then start the root
                S_FACT: begin
                    r_fs <= r_fs + 3'd1;
                    if (r_fs == 3'd0) begin
                        r_num <= 32'(fa[0]);
                        r_den <= 32'(fd[0]);
                    end else if (r_fs <= 3'd3) begin
                        r_num <= mul_p[31:0];
                    end else if (r_fs <= 3'd5) begin
                        r_den <= mul_p[31:0];
                    end else begin
                        r_state <= S_ROOT;
                    end
                end
                // wait for the root and file it
                S_ROOT: begin
                    if (root_done) begin
                        r_fs    <= '0;
                        r_state <= S_FACT;
                        unique case (r_job)
                            J_XI:    begin r_res.xi_coeff      <= pair_val; r_job <= J_ETA;   end
                            J_ETA:   begin r_res.eta_coeff     <= pair_val; r_job <= J_ZETA;  end
                            J_ZETA:  begin r_res.zeta_coeff    <= pair_val; r_job <= J_UPS;   end
                            J_UPS:   begin r_res.upsilon_coeff <= pair_val; r_job <= J_ALPHA; end
                            J_ALPHA: begin r_res.alpha_coeff   <= root_sat; r_job <= J_BETA;  end
                            J_BETA:  begin r_res.beta_coeff    <= root_sat; r_job <= J_S3;    end
                            J_S3: begin
                                r_p <= 64'(root_val);
                                r_k <= DEG_W'(2);
                                r_job <= (r_n > DEG_W'(2)) ? J_SK : J_Q;
                            end
                            J_SK, J_Q: begin
                                r_b     <= 64'(root_val);
                                r_acc   <= '0;
                                r_ms    <= '0;
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                // four partial products, then round
                S_MUL: begin
                    r_ms <= r_ms + 3'd1;
                    if (r_ms <= 3'd3) begin
                        r_acc <= r_acc + ({64'd0, mul_p} << mul_sh);
                    end else if (r_job == J_Q) begin
                        r_res.diag_coeff <= diag_val;
                        r_state          <= S_DONE;
                    end else begin
                        r_p     <= p_next;
                        r_k     <= r_k + 1'b1;
                        r_job   <= ((r_k + 1'b1) < r_n) ? J_SK : J_Q;
                        r_fs    <= '0;
                        r_state <= S_FACT;
                    end
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: design/legr_chk.sv
// port-level checks for the legendre recursion coefficient core
// depends on legr_pkg; bound to legendre_recursion_coefficients_core
module legr_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input legr_pkg::t_req               i_req,
    input logic                         o_done,
    input legr_pkg::t_res               o_res,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready,
    input logic [legr_pkg::DEG_W-1:0]   i_cfg_data
);
    import legr_pkg::*;

    // an accepted request always occupies the block
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // a result only follows work in progress
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in progress");

    // flagged requests carry zero coefficients
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_res.status != ST_OK) |->
            o_res.xi_coeff == '0 && o_res.eta_coeff == '0 &&
            o_res.zeta_coeff == '0 && o_res.upsilon_coeff == '0 &&
            o_res.alpha_coeff == '0 && o_res.beta_coeff == '0 &&
            o_res.diag_coeff == '0)
        else $error("flagged result has a non-zero coefficient");

endmodule

bind legendre_recursion_coefficients_core legr_chk u_legr_chk (.*);
